// ----- rtl/ibrgb_pkg.sv -----
// Shared types and constants for the indexed bitmap to RGB24 core.
`timescale 1ns / 1ps

package ibrgb_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // x / 3 == (x * 0xAAAB) >> 17 for any x below 2^16
    localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
    localparam int          DIV3_SHIFT = 17;

    localparam logic [14:0] ROW_ALIGN_MASK = ~15'd3;
    localparam logic [3:0]  NIBBLE_MASK    = 4'hF;

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_COLORS_USED  = 2'd3;

    // request op codes
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_PIXEL_BYTE    = 1'b1;

    typedef enum logic [1:0] {
        FMT_4BPP  = 2'd0,
        FMT_8BPP  = 2'd1,
        FMT_RGB24 = 2'd2
    } fmt_t;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [8:0]  colors_used;
    } ibrgb_cfg_t;

    // one queued job: a palette write, one or two pixels of one byte, or one 24-bit pixel
    typedef struct packed {
        logic        is_write;  // palette write: slot in idx0, color in rgb
        logic        direct;    // 24-bit pixel, color carried in rgb
        logic        two;       // two pixels (4 bpp pair)
        logic [7:0]  idx0;
        logic [7:0]  idx1;
        logic        bad0;
        logic        bad1;
        logic [23:0] rgb;       // {red, green, blue}
        logic [11:0] col;       // column of first pixel
        logic [11:0] row;
    } ibrgb_job_t;

endpackage

// ----- rtl/ibrgb_queue.sv -----
// Small register FIFO of jobs between the front and the back.
`timescale 1ns / 1ps

module ibrgb_queue
    import ibrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ibrgb_job_t push_job,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output ibrgb_job_t head
);

    ibrgb_job_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/ibrgb_front.sv -----
// Front end: accepts requests, tracks row/frame position, classifies bytes into jobs.
`timescale 1ns / 1ps

module ibrgb_front
    import ibrgb_pkg::*;
#(
    parameter int PALETTE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ibrgb_cfg_t  cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  palette_slot,
    input  logic [7:0]  palette_red,
    input  logic [7:0]  palette_green,
    input  logic [7:0]  palette_blue,
    input  logic [7:0]  data_byte,
    input  logic        q_full,
    output logic        q_push,
    output ibrgb_job_t  q_job
);

    logic [13:0] byte_in_row_reg, byte_in_row_next;
    logic [11:0] row_count_reg, row_count_next;
    logic [15:0] partial_color_reg, partial_color_next;
    logic [1:0]  color_phase_reg, color_phase_next;
    logic        frame_aborted_reg, frame_aborted_next;

    logic        accept;
    logic [12:0] w_eff, h_eff;
    logic [14:0] w3;
    logic [12:0] half_w;
    logic [13:0] row_len;
    logic        row_end;
    logic        frame_end;
    logic [8:0]  limit;
    logic [14:0] col2;
    logic [29:0] div_prod;
    logic [29:0] div_quot;
    logic [7:0]  nib_hi, nib_lo;
    logic        bad_hi, bad_lo;
    logic        abort_set;
    logic        push_pix;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // dimension clamping: 0 means 1, saturate at the maximum
    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = 13'd1;
        else if (32'(cfg.image_width) > MAX_WIDTH)
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = cfg.image_width;

        if (cfg.image_height == '0)
            h_eff = 13'd1;
        else if (32'(cfg.image_height) > MAX_HEIGHT)
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = cfg.image_height;
    end

    assign w3     = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
    assign half_w = 13'(({1'b0, w_eff} + 14'd1) >> 1);

    always_comb
    begin
        unique case (cfg.pixel_format)
            FMT_4BPP:
                row_len = 14'(({2'b00, half_w} + 15'd3) & ROW_ALIGN_MASK);
            FMT_8BPP:
                row_len = 14'(({2'b00, w_eff} + 15'd3) & ROW_ALIGN_MASK);
            default:
                row_len = 14'((w3 + 15'd3) & ROW_ALIGN_MASK);
        endcase
    end

    assign row_end   = ({1'b0, byte_in_row_reg} + 15'd1) >= {1'b0, row_len};
    assign frame_end = ({1'b0, row_count_reg} + 13'd1) >= h_eff;

    assign limit = (cfg.colors_used == '0 || 32'(cfg.colors_used) > PALETTE_DEPTH)
                   ? 9'(PALETTE_DEPTH) : cfg.colors_used;

    assign col2     = {byte_in_row_reg, 1'b0};
    assign div_prod = 30'(byte_in_row_reg) * 30'(DIV3_RECIP);
    assign div_quot = div_prod >> DIV3_SHIFT;
    assign nib_hi   = {4'b0000, data_byte[7:4] & NIBBLE_MASK};
    assign nib_lo   = {4'b0000, data_byte[3:0] & NIBBLE_MASK};
    assign bad_hi   = {1'b0, nib_hi} >= limit;
    assign bad_lo   = {1'b0, nib_lo} >= limit;

    always_comb
    begin
        q_job              = '0;
        q_job.row          = row_count_reg;
        push_pix           = 1'b0;
        abort_set          = 1'b0;
        q_push             = 1'b0;
        byte_in_row_next   = byte_in_row_reg;
        row_count_next     = row_count_reg;
        partial_color_next = partial_color_reg;
        color_phase_next   = color_phase_reg;
        frame_aborted_next = frame_aborted_reg;

        if (accept && op == OP_PALETTE_WRITE)
        begin
            q_job.is_write = 1'b1;
            q_job.idx0     = palette_slot;
            q_job.rgb      = {palette_red, palette_green, palette_blue};
            q_push         = ({1'b0, palette_slot} < 9'(PALETTE_DEPTH));
        end
        else if (accept)
        begin
            unique case (cfg.pixel_format)
                FMT_4BPP:
                begin
                    q_job.col  = col2[11:0];
                    q_job.idx0 = nib_hi;
                    q_job.idx1 = nib_lo;
                    q_job.bad0 = bad_hi;
                    q_job.bad1 = bad_lo;
                    if (col2 < {2'b00, w_eff} && !frame_aborted_reg)
                    begin
                        push_pix  = 1'b1;
                        q_job.two = !bad_hi && ((col2 + 15'd1) < {2'b00, w_eff});
                        abort_set = bad_hi || (q_job.two && bad_lo);
                    end
                end
                FMT_8BPP:
                begin
                    q_job.col  = byte_in_row_reg[11:0];
                    q_job.idx0 = data_byte;
                    q_job.bad0 = {1'b0, data_byte} >= limit;
                    if (byte_in_row_reg < {1'b0, w_eff} && !frame_aborted_reg)
                    begin
                        push_pix  = 1'b1;
                        abort_set = q_job.bad0;
                    end
                end
                default:
                begin
                    q_job.direct = 1'b1;
                    q_job.col    = div_quot[11:0];
                    q_job.rgb    = {data_byte, partial_color_reg};
                    if ({1'b0, byte_in_row_reg} < w3)
                    begin
                        case (color_phase_reg)
                            2'd0:
                            begin
                                partial_color_next = {8'h00, data_byte};
                                color_phase_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                partial_color_next = {data_byte, partial_color_reg[7:0]};
                                color_phase_next   = 2'd2;
                            end
                            default:
                            begin
                                color_phase_next = 2'd0;
                                push_pix         = !frame_aborted_reg;
                            end
                        endcase
                    end
                end
            endcase

            q_push             = push_pix;
            frame_aborted_next = frame_aborted_reg || abort_set;

            if (row_end)
            begin
                byte_in_row_next   = '0;
                color_phase_next   = '0;
                partial_color_next = '0;
                if (frame_end)
                begin
                    row_count_next     = '0;
                    frame_aborted_next = 1'b0;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                end
            end
            else
            begin
                byte_in_row_next = byte_in_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg   <= '0;
            row_count_reg     <= '0;
            partial_color_reg <= '0;
            color_phase_reg   <= '0;
            frame_aborted_reg <= 1'b0;
        end
        else
        begin
            byte_in_row_reg   <= byte_in_row_next;
            row_count_reg     <= row_count_next;
            partial_color_reg <= partial_color_next;
            color_phase_reg   <= color_phase_next;
            frame_aborted_reg <= frame_aborted_next;
        end
    end

endmodule

// ----- rtl/ibrgb_back.sv -----
// Back end: palette memory, per-pixel lookup and the output register.
`timescale 1ns / 1ps

module ibrgb_back
    import ibrgb_pkg::*;
#(
    parameter int PALETTE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  ibrgb_job_t  q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_red,
    output logic [7:0]  pixel_green,
    output logic [7:0]  pixel_blue,
    output logic [11:0] pixel_column,
    output logic [11:0] pixel_row,
    output logic        bad_index,
    output logic        last_of_item
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [23:0] pal_mem [PALETTE_DEPTH];

    logic        sub_reg, sub_next;
    logic        b_valid_reg, b_valid_next;
    logic        b_direct_reg, b_bad_reg, b_last_reg;
    logic [23:0] b_rgb_reg;
    logic [11:0] b_col_reg, b_row_reg;
    logic [23:0] rd_data_reg;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_rgb_reg;
    logic [11:0] out_col_reg, out_row_reg;
    logic        out_bad_reg, out_last_reg;

    logic        b_adv;
    logic        issue_pix;
    logic        pal_we;
    logic [AW-1:0] rd_addr;
    logic [23:0] b_color;

    assign b_adv     = b_valid_reg && (!out_valid_reg || out_ready);
    assign pal_we    = !q_empty && q_head.is_write;
    assign issue_pix = !q_empty && !q_head.is_write && (!b_valid_reg || b_adv);
    assign q_pop     = pal_we || (issue_pix && (!q_head.two || sub_reg));
    assign rd_addr   = sub_reg ? q_head.idx1[AW-1:0] : q_head.idx0[AW-1:0];

    always_comb
    begin
        sub_next       = issue_pix ? (q_head.two && !sub_reg) : sub_reg;
        b_valid_next   = issue_pix ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        out_valid_next = b_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // writes and reads stay in queue order, so a lookup sees every earlier write
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[q_head.idx0[AW-1:0]] <= q_head.rgb;
        end
        if (issue_pix)
        begin
            rd_data_reg <= pal_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_pix)
        begin
            b_direct_reg <= q_head.direct;
            b_bad_reg    <= sub_reg ? q_head.bad1 : q_head.bad0;
            b_last_reg   <= !q_head.two || sub_reg;
            b_rgb_reg    <= q_head.rgb;
            b_col_reg    <= q_head.col + {11'd0, sub_reg};
            b_row_reg    <= q_head.row;
        end
        if (b_adv)
        begin
            out_rgb_reg  <= b_color;
            out_col_reg  <= b_col_reg;
            out_row_reg  <= b_row_reg;
            out_bad_reg  <= b_bad_reg;
            out_last_reg <= b_last_reg;
        end
    end

    assign b_color = b_bad_reg ? 24'd0 : (b_direct_reg ? b_rgb_reg : rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_red    = out_rgb_reg[23:16];
    assign pixel_green  = out_rgb_reg[15:8];
    assign pixel_blue   = out_rgb_reg[7:0];
    assign pixel_column = out_col_reg;
    assign pixel_row    = out_row_reg;
    assign bad_index    = out_bad_reg;
    assign last_of_item = out_last_reg;

endmodule

// ----- rtl/indexed_bitmap_to_rgb24_core.sv -----
// Top level of the indexed bitmap to RGB24 core: config registers, front, queue, back.
`timescale 1ns / 1ps

// Usage:
//   Request channel (in_valid/in_ready): op 0 writes a palette entry
//   (palette_slot, palette_red/green/blue); op 1 carries the next byte of
//   the stored pixel array, row padding included, in data_byte.
//   Result channel (out_valid/out_ready): one pixel per transfer with its
//   color, column, stored row, bad_index and last_of_item flags. A 4 bpp
//   byte gives up to two pixels; padding bytes and palette writes give none.
//   Config port: cfg_write with cfg_index/cfg_data, write only while idle.
// Path: after acceptance, the first pixel of a request passes through the
//   queue register, the palette read register and the output register.
// Throughput: the front takes one request per cycle while the job queue
//   has room; the back emits one pixel per cycle while out_ready allows it,
//   through its single palette read port, so a 4 bpp pair is looked up in turn.
// Reset: config returns to 8 bpp, 1x1, all colors; position, queue and
//   output clear at once. Palette contents are undefined until written.
// Stall: a held result keeps the back busy; the job queue holds up to
//   four jobs before in_ready drops.

module indexed_bitmap_to_rgb24_core
    import ibrgb_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  palette_slot,
    input  logic [7:0]  palette_red,
    input  logic [7:0]  palette_green,
    input  logic [7:0]  palette_blue,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_red,
    output logic [7:0]  pixel_green,
    output logic [7:0]  pixel_blue,
    output logic [11:0] pixel_column,
    output logic [11:0] pixel_row,
    output logic        bad_index,
    output logic        last_of_item
);

    ibrgb_cfg_t cfg_reg, cfg_next;

    logic       q_push, q_full, q_pop, q_empty;
    ibrgb_job_t q_job, q_head;

    // configuration register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[1:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                CFG_COLORS_USED:  cfg_next.colors_used  = cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= FMT_8BPP;
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 13'd1;
            cfg_reg.colors_used  <= 9'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: position tracking and classification of each request
    ibrgb_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .palette_slot  (palette_slot),
        .palette_red   (palette_red),
        .palette_green (palette_green),
        .palette_blue  (palette_blue),
        .data_byte     (data_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job)
    );

    // job queue decouples request acceptance from pixel emission
    ibrgb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // back: palette writes, lookups and the result register
    ibrgb_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_red    (pixel_red),
        .pixel_green  (pixel_green),
        .pixel_blue   (pixel_blue),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .bad_index    (bad_index),
        .last_of_item (last_of_item)
    );

    // the front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // a bad index always carries a black pixel
    a_bad_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_index) |->
        (pixel_red == 8'd0 && pixel_green == 8'd0 && pixel_blue == 8'd0))
        else $error("bad index with nonzero color");

    // a bad index ends its byte: the first pixel of a pair is never bad
    a_pair_head_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_item) |-> !bad_index)
        else $error("bad index followed by a second pixel");

endmodule
